### design/pba_pkg.sv
// Shared types, constants and helper functions for the page bitmap allocator.
package pba_pkg;

  localparam int PAGE_COUNT = 512;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int PAGE_W    = 9;
  localparam int RES_W     = 10;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONE_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number_out;
    logic [1:0]        status;
  } rsp_t;

  // Free bits of word w for pages in [lo, PAGE_COUNT).
  function automatic logic [WORD_BITS-1:0] span_mask(logic [WADDR_W-1:0] w,
                                                     logic [RES_W-1:0] lo);
    logic [WORD_BITS-1:0] m;
    int page;
    m = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      page = int'(w) * WORD_BITS + b;
      m[b] = (page >= int'(lo)) && (page < PAGE_COUNT);
    end
    return m;
  endfunction

endpackage

### design/page_bitmap_allocator_top.sv
// Top level of the page bitmap allocator with its bitmap memory and sequencer.
//
// Requests arrive on req with req_valid; a request is taken at a clock edge
// where req_valid is high and req_stall is low. Each request yields exactly
// one response on rsp with rsp_valid, taken when rsp_stall is low.
// The block works on one request at a time; the bitmap is a 16 x 32 memory
// with a registered read port, read and written back by the sequencer.
// Allocate scans one word per cycle from word 0. Reinitialize makes one memory
// write per word. The next request is taken in the cycle after the response
// is loaded. A stalled response does not hold off the next request; that
// request is worked and then waits until the output register frees, and only
// after that is a further request taken. reserved_pages is written through
// cfg_we and cfg_data; the user is to write it only while idle, which the
// block itself does not enforce. It is used by reinitialize only. Reset clears
// reserved_pages to zero and marks every page free at once through per-word
// valid bits, with no clearing pass.
module page_bitmap_allocator_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  pba_pkg::req_t           req,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output pba_pkg::rsp_t           rsp,
  input  logic                    cfg_we,
  input  logic [pba_pkg::RES_W-1:0] cfg_data
);
  import pba_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FREE = 5'b00100,
    S_INIT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] word_valid;

  logic                 mem_re;
  logic [WADDR_W-1:0]   mem_raddr;
  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_vld;
  logic [WADDR_W-1:0]   rd_idx;
  logic [WORD_BITS-1:0] word;
  logic [BIT_W-1:0]     msb_idx;

  logic [RES_W-1:0]     reserved_pages;
  logic [PAGE_W-1:0]    free_page;
  logic [WADDR_W-1:0]   sweep_idx, sweep_idx_next;
  rsp_t                 res, res_next;
  logic                 accept;
  logic                 load_rsp;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign load_rsp  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  assign word = rd_vld ? rd_data : span_mask(rd_idx, '0);

  pba_msb u_msb (
    .word (word),
    .idx  (msb_idx)
  );

  always_comb begin
    state_next     = state;
    res_next       = res;
    sweep_idx_next = sweep_idx;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    mem_we         = 1'b0;
    mem_waddr      = rd_idx;
    mem_wdata      = word;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_next = '{page_number_out: '0, status: ST_OK};
          case (req.operation)
            OP_ALLOC: begin
              mem_re     = 1'b1;
              mem_raddr  = '0;
              state_next = S_SCAN;
            end
            OP_FREE: begin
              if (int'(req.page_number) >= PAGE_COUNT) begin
                res_next.status = ST_RANGE;
                state_next      = S_DONE;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = req.page_number[BIT_W +: WADDR_W];
                state_next = S_FREE;
              end
            end
            OP_INIT: begin
              sweep_idx_next = '0;
              state_next     = S_INIT;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (word != '0) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx;
          mem_wdata = word & ~(WORD_BITS'(1) << msb_idx);
          res_next  = '{page_number_out: PAGE_W'({rd_idx, msb_idx}), status: ST_OK};
          state_next = S_DONE;
        end else if (rd_idx == WADDR_W'(NUM_WORDS - 1)) begin
          res_next.status = ST_NONE_FREE;
          state_next      = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_idx + WADDR_W'(1);
        end
      end
      S_FREE: begin
        mem_we     = 1'b1;
        mem_waddr  = rd_idx;
        mem_wdata  = word | (WORD_BITS'(1) << free_page[BIT_W-1:0]);
        state_next = S_DONE;
      end
      S_INIT: begin
        mem_we         = 1'b1;
        mem_waddr      = sweep_idx;
        mem_wdata      = span_mask(sweep_idx, reserved_pages);
        sweep_idx_next = sweep_idx + WADDR_W'(1);
        if (sweep_idx == WADDR_W'(NUM_WORDS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
      rd_vld  <= word_valid[mem_raddr] || (mem_we && mem_waddr == mem_raddr);
      rd_idx  <= mem_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (mem_we) begin
      word_valid[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      reserved_pages <= '0;
      rsp_valid      <= 1'b0;
      sweep_idx      <= '0;
    end else begin
      state     <= state_next;
      sweep_idx <= sweep_idx_next;
      if (cfg_we) begin
        reserved_pages <= cfg_data;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (accept) begin
      free_page <= req.page_number;
    end
    if (load_rsp) begin
      rsp <= res;
    end
  end

endmodule

### design/pba_msb.sv
// Priority encoder that returns the index of the highest set bit of a bitmap word.
module pba_msb (
  input  logic [pba_pkg::WORD_BITS-1:0] word,
  output logic [pba_pkg::BIT_W-1:0]     idx
);
  import pba_pkg::*;

  always_comb begin
    idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (word[b]) begin
        idx = BIT_W'(b);
      end
    end
  end

endmodule
